### hdl/lattice_cell_and_corner_index_assert.svh
// Assertion macros for the lattice cell and corner index block.
`ifndef LATTICE_CELL_AND_CORNER_INDEX_ASSERT_SVH
`define LATTICE_CELL_AND_CORNER_INDEX_ASSERT_SVH

// Antecedent implies consequent in the same cycle, checked outside reset.
`define LCCI_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lcci assertion failed");

// Antecedent implies consequent in the next cycle, also checked during reset.
`define LCCI_ASSERT_NEXT(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("lcci assertion failed");

`endif

### hdl/lcci_pkg.sv
// Package with the types and constants of the lattice cell and corner index block.
`timescale 1ns / 1ps
`default_nettype none
package lcci_pkg;

   localparam int POS_W     = 32;
   localparam int LPOS_W    = POS_W + 1;
   localparam int INV_W     = 24;
   localparam int OFS_W     = 16;
   localparam int CNT_W     = 8;
   localparam int PROD_W    = LPOS_W + INV_W;
   localparam int FRAC_W    = 16;
   localparam int REL_W     = PROD_W - FRAC_W + 1;
   localparam int IDX_W     = 22;
   localparam int NUM_IDX   = 8;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_W     = 32;
   localparam int SCALE_STG = 3;
   localparam int INDEX_STG = 3;
   localparam int NUM_STG   = SCALE_STG + INDEX_STG;
   localparam int REQ_W     = 3 * POS_W;
   localparam int RSP_W     = NUM_IDX * IDX_W + 3 * FRAC_W;

   localparam logic [INV_W-1:0] INV_RESET   = 24'd65536;
   localparam logic [CNT_W-1:0] CELLS_RESET = 8'd16;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ORIGIN_X    = 3'd0,
      CSR_ORIGIN_Y    = 3'd1,
      CSR_ORIGIN_Z    = 3'd2,
      CSR_INV_SPACING = 3'd3,
      CSR_GRID_OFFSET = 3'd4,
      CSR_CELLS_X     = 3'd5,
      CSR_CELLS_Y     = 3'd6,
      CSR_CELLS_Z     = 3'd7
   } csr_addr_type;

   typedef struct packed {
      logic [CNT_W-1:0]  cell_num;
      logic [FRAC_W-1:0] frac;
      logic              err;
   } cell_res_type;

endpackage
`default_nettype wire

### hdl/lcci_scale.sv
// One axis: origin subtract, reciprocal-spacing multiply, cell and fraction split.
`timescale 1ns / 1ps
`default_nettype none
module lcci_scale (
   input  wire logic                                  clock,
   input  wire logic [lcci_pkg::SCALE_STG-1:0]        en,
   input  wire logic signed [lcci_pkg::POS_W-1:0]     pos,
   input  wire logic signed [lcci_pkg::POS_W-1:0]     origin,
   input  wire logic [lcci_pkg::INV_W-1:0]            inv_spacing,
   input  wire logic [lcci_pkg::OFS_W-1:0]            grid_offset,
   input  wire logic [lcci_pkg::CNT_W-1:0]            cells,
   output      lcci_pkg::cell_res_type                res
);

   localparam int CELL_SW = lcci_pkg::REL_W - lcci_pkg::FRAC_W;

   logic signed [lcci_pkg::LPOS_W-1:0]   lpos_ff, lpos_in;
   logic signed [lcci_pkg::PROD_W:0]     prod_full;
   logic signed [lcci_pkg::PROD_W-1:0]   prod_ff, prod_in;
   logic signed [lcci_pkg::REL_W-1:0]    rel;
   logic [CELL_SW-2:0]                   cell_mag;
   logic                                 minus_one;
   logic                                 over;
   lcci_pkg::cell_res_type               res_ff, res_in;

   always_comb begin
      lpos_in   = {pos[lcci_pkg::POS_W-1], pos} - {origin[lcci_pkg::POS_W-1], origin};
      prod_full = lpos_ff * $signed({1'b0, inv_spacing});
      prod_in   = prod_full[lcci_pkg::PROD_W-1:0];
   end

   always_comb begin
      rel = {prod_ff[lcci_pkg::PROD_W-1], prod_ff[lcci_pkg::PROD_W-1:lcci_pkg::FRAC_W]}
            + {{(lcci_pkg::REL_W-lcci_pkg::OFS_W){1'b0}}, grid_offset};
      cell_mag  = rel[lcci_pkg::REL_W-2:lcci_pkg::FRAC_W];
      minus_one = &rel;
      over      = cell_mag > (CELL_SW-1)'(cells);
      if (minus_one) begin
         res_in.cell_num = '0;
         res_in.frac     = '0;
         res_in.err      = 1'b0;
      end else begin
         res_in.cell_num = cell_mag[lcci_pkg::CNT_W-1:0];
         res_in.frac     = rel[lcci_pkg::FRAC_W-1:0];
         res_in.err      = rel[lcci_pkg::REL_W-1] | over;
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         lpos_ff <= lpos_in;
      end
      if (en[1]) begin
         prod_ff <= prod_in;
      end
      if (en[2]) begin
         res_ff <= res_in;
      end
   end

   assign res = res_ff;

endmodule
`default_nettype wire

### hdl/lcci_index.sv
// Linear node index of the lower corner and the seven neighbor corners.
`timescale 1ns / 1ps
`default_nettype none
module lcci_index #(
   parameter int PAD_W = 9
) (
   input  wire logic                                             clock,
   input  wire logic [lcci_pkg::INDEX_STG-1:0]                   en,
   input  wire lcci_pkg::cell_res_type                           res_x,
   input  wire lcci_pkg::cell_res_type                           res_y,
   input  wire lcci_pkg::cell_res_type                           res_z,
   input  wire logic [PAD_W-1:0]                                 pad_x,
   input  wire logic [PAD_W-1:0]                                 pad_y,
   output      logic [lcci_pkg::NUM_IDX-1:0][lcci_pkg::IDX_W-1:0] idx,
   output      logic [2:0][lcci_pkg::FRAC_W-1:0]                 frac,
   output      logic                                             status
);

   localparam int IN_W = PAD_W + lcci_pkg::CNT_W + 1;
   localparam int BP_W = PAD_W + IN_W;
   localparam int PL_W = 2 * PAD_W;

   logic [IN_W-1:0]                  inner_ff, inner_in;
   logic [PL_W-1:0]                  plane_ff, plane_in;
   logic [lcci_pkg::CNT_W-1:0]       cx_ff;
   logic [PAD_W-1:0]                 px3_ff, px4_ff;
   logic                             err3_ff, err4_ff;
   logic [2:0][lcci_pkg::FRAC_W-1:0] frac3_ff, frac4_ff;
   logic [BP_W-1:0]                  base_prod;
   logic [lcci_pkg::IDX_W-1:0]       base_ff, base_in;
   logic [lcci_pkg::IDX_W-1:0]       plane4_ff;
   logic [lcci_pkg::IDX_W-1:0]       up, px_w;
   logic [lcci_pkg::NUM_IDX-1:0][lcci_pkg::IDX_W-1:0] idx_ff, idx_in;
   logic [2:0][lcci_pkg::FRAC_W-1:0] frac_ff, frac_in;
   logic                             status_ff, status_in;

   always_comb begin
      inner_in  = IN_W'(res_y.cell_num) + IN_W'(pad_y) * IN_W'(res_z.cell_num);
      plane_in  = PL_W'(pad_x) * PL_W'(pad_y);
      base_prod = BP_W'(px3_ff) * BP_W'(inner_ff);
      base_in   = lcci_pkg::IDX_W'(base_prod) + lcci_pkg::IDX_W'(cx_ff);
   end

   always_comb begin
      up        = base_ff + plane4_ff;
      px_w      = lcci_pkg::IDX_W'(px4_ff);
      status_in = err4_ff;
      if (err4_ff) begin
         idx_in  = '0;
         frac_in = '0;
      end else begin
         idx_in[0] = base_ff;
         idx_in[1] = base_ff + 1'b1;
         idx_in[2] = base_ff + px_w;
         idx_in[3] = base_ff + px_w + 1'b1;
         idx_in[4] = up;
         idx_in[5] = up + 1'b1;
         idx_in[6] = up + px_w;
         idx_in[7] = up + px_w + 1'b1;
         frac_in   = frac4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         inner_ff <= inner_in;
         plane_ff <= plane_in;
         cx_ff    <= res_x.cell_num;
         px3_ff   <= pad_x;
         err3_ff  <= res_x.err | res_y.err | res_z.err;
         frac3_ff <= {res_z.frac, res_y.frac, res_x.frac};
      end
      if (en[1]) begin
         base_ff   <= base_in;
         plane4_ff <= lcci_pkg::IDX_W'(plane_ff);
         px4_ff    <= px3_ff;
         err4_ff   <= err3_ff;
         frac4_ff  <= frac3_ff;
      end
      if (en[2]) begin
         idx_ff    <= idx_in;
         frac_ff   <= frac_in;
         status_ff <= status_in;
      end
   end

   assign idx    = idx_ff;
   assign frac   = frac_ff;
   assign status = status_ff;

endmodule
`default_nettype wire

### hdl/lattice_cell_and_corner_index.sv
// Top level of the lattice cell and corner index block.
// Usage: each request item carries a particle position (x, y, z, signed Q16.16).
// The block subtracts the box origin, scales by the reciprocal lattice spacing,
// adds the grid offset and returns one response item per request: the eight
// corner node indices of the enclosing cell in a halo-padded linear layout,
// the upper interpolation fraction per axis and an out-of-region status flag.
// An item outside the local cells returns status 1 with all indices and
// fractions zero. The user must write registers on the csr port only while
// no item is in flight; the block itself does not enforce this. The six
// register stages are subtract, multiply, cell split, plane products, base
// index and corner adds. Throughput is one item per cycle while the receiver
// takes responses. Each stage holds its item while the next one is full, so
// when the receiver stalls the pipeline fills up and then stops taking
// requests; nothing is lost or repeated. Synchronous reset empties the
// pipeline and restores the register defaults.
`timescale 1ns / 1ps
`default_nettype none
module lattice_cell_and_corner_index #(
   parameter int MAX_CELLS  = 128,
   parameter int HALO_WIDTH = 1
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   output      logic                            req_tready,
   // pos_x, pos_y, pos_z
   input  wire logic [lcci_pkg::REQ_W-1:0]      req_tdata,
   output      logic                            rsp_tvalid,
   input  wire logic                            rsp_tready,
   // index_000, index_100, index_010, index_110, index_001, index_101,
   // index_011, index_111, frac_x, frac_y, frac_z
   output      logic [lcci_pkg::RSP_W-1:0]      rsp_tdata,
   // status
   output      logic                            rsp_tuser,
   input  wire logic                            csr_we,
   input  wire logic [lcci_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [lcci_pkg::CSR_W-1:0]      csr_wdata
);

   `include "lattice_cell_and_corner_index_assert.svh"

   localparam int PAD_W = $clog2((1 << lcci_pkg::CNT_W) + 2 * HALO_WIDTH);

   logic [2:0][lcci_pkg::POS_W-1:0]  origin_ff;
   logic [lcci_pkg::INV_W-1:0]       inv_ff;
   logic [lcci_pkg::OFS_W-1:0]       offset_ff;
   logic [2:0][lcci_pkg::CNT_W-1:0]  cells_ff;
   logic [2:0][lcci_pkg::CNT_W-1:0]  cells_sat;
   logic [2:0][PAD_W-1:0]            pad;
   logic [lcci_pkg::NUM_STG-1:0]     valid_ff, valid_in;
   logic [lcci_pkg::NUM_STG-1:0]     en;
   lcci_pkg::cell_res_type [2:0]     res;
   logic [lcci_pkg::NUM_IDX-1:0][lcci_pkg::IDX_W-1:0] idx;
   logic [2:0][lcci_pkg::FRAC_W-1:0] frac;
   logic                             status;
   lcci_pkg::csr_addr_type           csr_addr;

   assign csr_addr = lcci_pkg::csr_addr_type'(csr_index);

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_ff <= '0;
         inv_ff    <= lcci_pkg::INV_RESET;
         offset_ff <= '0;
         cells_ff  <= {3{lcci_pkg::CELLS_RESET}};
      end else if (csr_we) begin
         case (csr_addr)
            lcci_pkg::CSR_ORIGIN_X: begin
               origin_ff[0] <= csr_wdata;
            end
            lcci_pkg::CSR_ORIGIN_Y: begin
               origin_ff[1] <= csr_wdata;
            end
            lcci_pkg::CSR_ORIGIN_Z: begin
               origin_ff[2] <= csr_wdata;
            end
            lcci_pkg::CSR_INV_SPACING: begin
               inv_ff <= csr_wdata[lcci_pkg::INV_W-1:0];
            end
            lcci_pkg::CSR_GRID_OFFSET: begin
               offset_ff <= csr_wdata[lcci_pkg::OFS_W-1:0];
            end
            lcci_pkg::CSR_CELLS_X: begin
               cells_ff[0] <= csr_wdata[lcci_pkg::CNT_W-1:0];
            end
            lcci_pkg::CSR_CELLS_Y: begin
               cells_ff[1] <= csr_wdata[lcci_pkg::CNT_W-1:0];
            end
            lcci_pkg::CSR_CELLS_Z: begin
               cells_ff[2] <= csr_wdata[lcci_pkg::CNT_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      for (int d = 0; d < 3; d++) begin
         cells_sat[d] = (int'(cells_ff[d]) > MAX_CELLS) ? lcci_pkg::CNT_W'(MAX_CELLS)
                                                        : cells_ff[d];
         pad[d] = PAD_W'(cells_sat[d]) + PAD_W'(2 * HALO_WIDTH);
      end
   end

   always_comb begin
      en[lcci_pkg::NUM_STG-1] = !valid_ff[lcci_pkg::NUM_STG-1] || rsp_tready;
      for (int k = lcci_pkg::NUM_STG - 2; k >= 0; k--) begin
         en[k] = !valid_ff[k] || en[k+1];
      end
      valid_in[0] = en[0] ? req_tvalid : valid_ff[0];
      for (int k = 1; k < lcci_pkg::NUM_STG; k++) begin
         valid_in[k] = en[k] ? valid_ff[k-1] : valid_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   for (genvar d = 0; d < 3; d++) begin : g_axis
      lcci_scale u_scale (
         .clock       (clock),
         .en          (en[lcci_pkg::SCALE_STG-1:0]),
         .pos         (req_tdata[d*lcci_pkg::POS_W +: lcci_pkg::POS_W]),
         .origin      (origin_ff[d]),
         .inv_spacing (inv_ff),
         .grid_offset (offset_ff),
         .cells       (cells_sat[d]),
         .res         (res[d])
      );
   end

   lcci_index #(
      .PAD_W (PAD_W)
   ) u_index (
      .clock  (clock),
      .en     (en[lcci_pkg::NUM_STG-1:lcci_pkg::SCALE_STG]),
      .res_x  (res[0]),
      .res_y  (res[1]),
      .res_z  (res[2]),
      .pad_x  (pad[0]),
      .pad_y  (pad[1]),
      .idx    (idx),
      .frac   (frac),
      .status (status)
   );

   assign req_tready = en[0];
   assign rsp_tvalid = valid_ff[lcci_pkg::NUM_STG-1];
   assign rsp_tdata  = {frac, idx};
   assign rsp_tuser  = status;

   `LCCI_ASSERT_SAME(a_err_zero, clock, reset, rsp_tvalid && rsp_tuser, rsp_tdata == '0)
   `LCCI_ASSERT_SAME(a_ready_when_drained, clock, reset, !rsp_tvalid, req_tready)
   `LCCI_ASSERT_NEXT(a_reset_empty, clock, reset, !rsp_tvalid && valid_ff == '0)

endmodule
`default_nettype wire
